// ===== design/wgen_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform generator package
// Shared types, register map, sine table and scaling helpers.
// ----------------------------------------------------------------------------
package wgen_pkg;

  localparam int unsigned ACC_W        = 24;
  localparam int unsigned LEVEL_W      = 8;
  localparam int unsigned VOLTS_W      = 6;
  localparam int unsigned ELAPSED_W    = 16;
  localparam int unsigned SINE_STEPS   = 255;
  localparam int unsigned SINE_ROM_LEN = 200;

  localparam logic [ACC_W-1:0] ACC_MAX        = {ACC_W{1'b1}};
  localparam logic [ACC_W-1:0] SQUARE_PER_RST = 24'd500;
  localparam logic [ACC_W-1:0] TRI_PER_RST    = 24'd200;
  localparam logic [ACC_W-1:0] SINE_PER_RST   = 24'd200;

  typedef enum logic [1:0] {
    MODE_SQUARE   = 2'd0,
    MODE_TRIANGLE = 2'd1,
    MODE_SINE     = 2'd2,
    MODE_OFF      = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE       = 2'd0,
    REG_SQUARE_PER = 2'd1,
    REG_TRI_PER    = 2'd2,
    REG_SINE_PER   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    mode_e            mode;
    logic [ACC_W-1:0] square_period;
    logic [ACC_W-1:0] triangle_period;
    logic [ACC_W-1:0] sine_period;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               ramp_up;
    logic [7:0]         phase;
    logic [ACC_W-1:0]   accum;
  } gen_state_t;

  typedef struct packed {
    logic               fire;
    gen_state_t         next;
    logic [VOLTS_W-1:0] volts;
  } step_res_t;

  localparam logic [7:0] SINE_ROM [SINE_ROM_LEN] = '{
    8'd127, 8'd130, 8'd134, 8'd138, 8'd142, 8'd146, 8'd150, 8'd154, 8'd158, 8'd162,
    8'd166, 8'd170, 8'd173, 8'd177, 8'd181, 8'd184, 8'd188, 8'd191, 8'd195, 8'd198,
    8'd201, 8'd204, 8'd207, 8'd210, 8'd213, 8'd216, 8'd219, 8'd222, 8'd224, 8'd227,
    8'd229, 8'd232, 8'd234, 8'd236, 8'd238, 8'd240, 8'd241, 8'd243, 8'd245, 8'd246,
    8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd252, 8'd252, 8'd253, 8'd253, 8'd253,
    8'd253, 8'd253, 8'd253, 8'd253, 8'd252, 8'd252, 8'd251, 8'd250, 8'd250, 8'd248,
    8'd247, 8'd246, 8'd245, 8'd243, 8'd241, 8'd240, 8'd238, 8'd236, 8'd234, 8'd232,
    8'd229, 8'd227, 8'd224, 8'd222, 8'd219, 8'd216, 8'd213, 8'd210, 8'd207, 8'd204,
    8'd201, 8'd198, 8'd195, 8'd191, 8'd188, 8'd184, 8'd181, 8'd177, 8'd173, 8'd170,
    8'd166, 8'd162, 8'd158, 8'd154, 8'd150, 8'd146, 8'd142, 8'd138, 8'd134, 8'd131,
    8'd127, 8'd123, 8'd119, 8'd115, 8'd111, 8'd107, 8'd103, 8'd99,  8'd95,  8'd91,
    8'd87,  8'd83,  8'd80,  8'd76,  8'd72,  8'd69,  8'd65,  8'd62,  8'd58,  8'd55,
    8'd52,  8'd49,  8'd46,  8'd43,  8'd40,  8'd37,  8'd34,  8'd31,  8'd29,  8'd26,
    8'd24,  8'd21,  8'd19,  8'd17,  8'd15,  8'd13,  8'd12,  8'd10,  8'd8,   8'd7,
    8'd6,   8'd5,   8'd4,   8'd3,   8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd2,   8'd3,   8'd3,   8'd5,
    8'd6,   8'd7,   8'd8,   8'd10,  8'd12,  8'd13,  8'd15,  8'd17,  8'd19,  8'd21,
    8'd24,  8'd26,  8'd29,  8'd31,  8'd34,  8'd37,  8'd40,  8'd42,  8'd46,  8'd49,
    8'd52,  8'd55,  8'd58,  8'd62,  8'd65,  8'd69,  8'd72,  8'd76,  8'd80,  8'd83,
    8'd87,  8'd91,  8'd95,  8'd99,  8'd103, 8'd107, 8'd111, 8'd115, 8'd119, 8'd122
  };

  // Phase p maps to table row floor(p*200/255), clamped to the last row.
  // x/255 for x below 2^16 is (x + (x >> 8) + 1) >> 8.
  function automatic logic [7:0] sine_lookup(logic [7:0] p);
    logic [15:0] x;
    logic [16:0] s;
    logic [7:0]  q;
    x = 16'(p) * 16'd200;
    s = 17'(x) + 17'(x[15:8]) + 17'd1;
    q = s[15:8];
    if (q >= 8'(SINE_ROM_LEN)) begin
      q = 8'(SINE_ROM_LEN - 1);
    end
    return SINE_ROM[q];
  endfunction

  // level*33/255, truncated.
  function automatic logic [VOLTS_W-1:0] volts_of(logic [LEVEL_W-1:0] lvl);
    logic [13:0] x;
    logic [14:0] s;
    x = 14'(lvl) * 14'd33;
    s = 15'(x) + 15'(x[13:8]) + 15'd1;
    return s[13:8];
  endfunction

endpackage

// ===== design/waveform_generator_square_triangle_sine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square / triangle / sine waveform generator
// Tick accumulator stepping an 8-bit level, with scaled voltage output.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the result register is free or draining.
// An input register and then a result register separate the two stream sides,
// so one item is held while a result waits.
// Reset: asynchronous, active low; the state registers take their defaults,
// level 0, ramping upward, phase and accumulator cleared.
module waveform_generator_square_triangle_sine_top
  import wgen_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] elapsed
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] level, [13:8] volts_tenths, [15:14] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t                 cfg;
  logic                 mode_wr;
  gen_state_t           st_q, st_d;
  step_res_t            res;
  logic                 in_valid_q;
  logic [ELAPSED_W-1:0] in_elapsed_q;
  logic                 out_valid_q;
  logic [LEVEL_W-1:0]   out_level_q;
  logic [VOLTS_W-1:0]   out_volts_q;
  logic                 proc;
  logic                 in_acc;

  wgen_apb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .mode_wr_o (mode_wr)
  );

  wgen_step u_step (
    .cfg_i     (cfg),
    .state_i   (st_q),
    .elapsed_i (in_elapsed_q),
    .res_o     (res)
  );

  // process the held item when the result register is free or draining
  assign proc          = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | proc;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  always_comb begin
    st_d = st_q;
    if (proc) begin
      st_d = res.next;
    end
    // a mode write clears the level only
    if (mode_wr) begin
      st_d.level = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.level   <= '0;
      st_q.ramp_up <= 1'b1;
      st_q.phase   <= '0;
      st_q.accum   <= '0;
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      st_q <= st_d;
      if (in_acc) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (proc && res.fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_elapsed_q <= s_axis_tdata;
    end
    if (proc && res.fire) begin
      out_level_q <= res.next.level;
      out_volts_q <= res.volts;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_volts_q, out_level_q};

endmodule

// ===== design/wgen_apb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform generator register file
// APB-style write/read access to mode and the three step periods.
// ----------------------------------------------------------------------------
module wgen_apb_regs
  import wgen_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o,
  output logic        mode_wr_o
);

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_comb begin
    cfg_d     = cfg_q;
    mode_wr_o = 1'b0;
    if (wr_en) begin
      unique case (idx)
        REG_MODE: begin
          cfg_d.mode = mode_e'(pwdata[1:0]);
          mode_wr_o  = 1'b1;
        end
        REG_SQUARE_PER: cfg_d.square_period   = pwdata[ACC_W-1:0];
        REG_TRI_PER:    cfg_d.triangle_period = pwdata[ACC_W-1:0];
        REG_SINE_PER:   cfg_d.sine_period     = pwdata[ACC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:       prdata = 32'(cfg_q.mode);
      REG_SQUARE_PER: prdata = 32'(cfg_q.square_period);
      REG_TRI_PER:    prdata = 32'(cfg_q.triangle_period);
      REG_SINE_PER:   prdata = 32'(cfg_q.sine_period);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode            <= MODE_SQUARE;
      cfg_q.square_period   <= SQUARE_PER_RST;
      cfg_q.triangle_period <= TRI_PER_RST;
      cfg_q.sine_period     <= SINE_PER_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/wgen_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform generator step logic
// Accumulates elapsed ticks and computes the next level for one item.
// ----------------------------------------------------------------------------
module wgen_step
  import wgen_pkg::*;
(
  input  cfg_t                 cfg_i,
  input  gen_state_t           state_i,
  input  logic [ELAPSED_W-1:0] elapsed_i,
  output step_res_t            res_o
);

  logic [ACC_W:0]     sum;
  logic [ACC_W-1:0]   acc_sat;
  logic [ACC_W-1:0]   period;
  logic [LEVEL_W-1:0] tri_lvl;
  logic [7:0]         phase_inc;

  assign sum     = {1'b0, state_i.accum} + (ACC_W+1)'(elapsed_i);
  assign acc_sat = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];

  always_comb begin
    case (cfg_i.mode)
      MODE_SQUARE:   period = cfg_i.square_period;
      MODE_TRIANGLE: period = cfg_i.triangle_period;
      default:       period = cfg_i.sine_period;
    endcase
  end

  assign tri_lvl   = state_i.ramp_up ? state_i.level + 8'd1 : state_i.level - 8'd1;
  assign phase_inc = state_i.phase + 8'd1;

  always_comb begin
    res_o.fire  = 1'b0;
    res_o.next  = state_i;
    if (cfg_i.mode != MODE_OFF) begin
      if (acc_sat >= period) begin
        res_o.fire       = 1'b1;
        res_o.next.accum = '0;
        case (cfg_i.mode)
          MODE_SQUARE: res_o.next.level = ~state_i.level;
          MODE_TRIANGLE: begin
            res_o.next.level = tri_lvl;
            if (tri_lvl == 8'hFF) begin
              res_o.next.ramp_up = 1'b0;
            end else if (tri_lvl == 8'h00) begin
              res_o.next.ramp_up = 1'b1;
            end
          end
          default: begin
            res_o.next.level = sine_lookup(state_i.phase);
            // wrap the phase once it reaches the step count
            res_o.next.phase = (phase_inc >= 8'(SINE_STEPS)) ? 8'd0 : phase_inc;
          end
        endcase
      end else begin
        res_o.next.accum = acc_sat;
      end
    end
    res_o.volts = volts_of(res_o.next.level);
  end

endmodule
